// ===== rtl/coap_pkg.sv =====
// ============================================================================
// coap_pkg
// shared types and constants of the coap message parser: request and result
// payloads, parser state, phase encoding, result kinds and error codes
// ============================================================================
`default_nettype none

package coap_pkg;

    localparam logic [3:0] MAX_TOKEN_BYTES = 4'd8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] KIND_HDR_BYTE = 3'd0;
    localparam logic [2:0] KIND_HDR_DONE = 3'd1;
    localparam logic [2:0] KIND_TOKEN    = 3'd2;
    localparam logic [2:0] KIND_OPT_DONE = 3'd3;
    localparam logic [2:0] KIND_VALUE    = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd5;
    localparam logic [2:0] KIND_OK       = 3'd6;
    localparam logic [2:0] KIND_ERROR    = 3'd7;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_SHORT_HDR   = 3'd1;
    localparam logic [2:0] ERR_TRUNC_TOKEN = 3'd2;
    localparam logic [2:0] ERR_RESERVED    = 3'd3;
    localparam logic [2:0] ERR_TRUNC_OPT   = 3'd4;
    localparam logic [2:0] ERR_TRUNC_VALUE = 3'd5;
    localparam logic [2:0] ERR_TOKEN_LONG  = 3'd6;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd7;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_TOKEN   = 7'b0000010,
        PH_OPTHDR  = 7'b0000100,
        PH_OPTEXT  = 7'b0001000,
        PH_VALUE   = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_DISCARD = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic [7:0]  byte_value;
        logic [16:0] byte_index;
        logic [2:0]  error_code;
        logic        end_of_run;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  header_count;
        logic [31:0] header_fields;
        logic [16:0] remaining;
        logic [15:0] option_num;
        logic [7:0]  pending;
        logic [15:0] ext_bytes;
        logic [2:0]  ext_count;
        logic [2:0]  err_latched;
        logic [16:0] option_len;
        logic [16:0] item_index;
    } state_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } step_t;

    localparam state_t STATE_CLEAR = '{
        phase:         PH_HEADER,
        header_count:  2'd0,
        header_fields: 32'd0,
        remaining:     17'd0,
        option_num:    16'd0,
        pending:       8'd0,
        ext_bytes:     16'd0,
        ext_count:     3'd0,
        err_latched:   3'd0,
        option_len:    17'd0,
        item_index:    17'd0
    };

endpackage

`default_nettype wire

// ===== rtl/coap_message_parser.sv =====
// ============================================================================
// coap_message_parser
// byte-serial coap message parser with a result queue
// ============================================================================
// one datagram byte per request on the byte channel; the last byte of a
// datagram carries last_byte set
// every request gives one result on the result channel; a last byte that
// does not hit an error gives a second result, message ok or error
// the parser state is updated in the cycle the request is taken, and its
// results enter a four-entry queue; with the queue empty, the first result
// shows in the cycle after the request
// throughput is one byte per cycle while the receiver takes results; a last
// byte with two results leaves the queue one more result to drain
// byte_ready drops while the queue holds more than two results, so a stalled
// receiver stops the byte channel without loss
// reset clears the parser to the start of a datagram and empties the queue;
// after a last byte the parser starts over on its own
// ============================================================================
`default_nettype none

module coap_message_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  coap_pkg::byte_t   byte_item,
    output logic              result_valid,
    input  logic              result_ready,
    output coap_pkg::result_t result_item
);
    import coap_pkg::*;

    state_t state_reg;
    state_t state_next;
    state_t step_state;
    step_t  step_res;
    logic   accept;

    assign accept = byte_valid && byte_ready;

    coap_step u_step (
        .cur  (state_reg),
        .item (byte_item),
        .nxt  (step_state),
        .res  (step_res)
    );

    assign state_next = accept ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    coap_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .entry      (step_res),
        .room       (byte_ready),
        .pop        (result_ready),
        .head_valid (result_valid),
        .head       (result_item)
    );

endmodule

`default_nettype wire

// ===== rtl/coap_step.sv =====
// ============================================================================
// coap_step
// next-state and result logic of the parser for one datagram byte
// ============================================================================
`default_nettype none

module coap_step (
    input  coap_pkg::state_t cur,
    input  coap_pkg::byte_t  item,
    output coap_pkg::state_t nxt,
    output coap_pkg::step_t  res
);
    import coap_pkg::*;

    function automatic logic [1:0] ext_need(input logic [3:0] nib);
        logic [1:0] n;
        n = 2'd0;
        if (nib == 4'd13)
        begin
            n = 2'd1;
        end
        else if (nib == 4'd14)
        begin
            n = 2'd2;
        end
        return n;
    endfunction

    function automatic logic [16:0] ext_value(input logic [1:0] need, input logic [3:0] nib,
                                              input logic [15:0] ext);
        logic [16:0] v;
        v = {13'd0, nib};
        if (need == 2'd1)
        begin
            v = {1'b0, ext} + 17'd13;
        end
        else if (need == 2'd2)
        begin
            v = {1'b0, ext} + 17'd269;
        end
        return v;
    endfunction

    state_t      st;
    logic [2:0]  kind;
    logic [16:0] idx;
    logic        fail_now;
    logic [2:0]  fail_code;
    logic        start_now;
    logic [16:0] start_len;
    logic [7:0]  b;
    logic [3:0]  d;
    logic [3:0]  l;
    logic [1:0]  dn;
    logic [1:0]  ln;
    logic [3:0]  pd;
    logic [3:0]  pl;
    logic [1:0]  pdn;
    logic [1:0]  pln;
    logic [2:0]  got;
    logic [15:0] ext_new;
    logic [16:0] delta;
    logic [17:0] sum;
    logic [3:0]  tkl;
    logic [2:0]  fin_err;
    result_t     r0;
    result_t     r1;

    always_comb
    begin
        st        = cur;
        kind      = KIND_HDR_BYTE;
        idx       = '0;
        fail_now  = 1'b0;
        fail_code = ERR_NONE;
        start_now = 1'b0;
        start_len = '0;
        b         = item.data_byte;
        d         = b[7:4];
        l         = b[3:0];
        dn        = ext_need(d);
        ln        = ext_need(l);
        pd        = cur.pending[7:4];
        pl        = cur.pending[3:0];
        pdn       = ext_need(pd);
        pln       = ext_need(pl);
        got       = ({1'b0, pdn} + {1'b0, pln}) - cur.ext_count;
        ext_new   = {cur.ext_bytes[7:0], b};
        delta     = '0;
        sum       = '0;
        tkl       = '0;

        unique case (cur.phase)
            PH_HEADER:
            begin
                unique case (cur.header_count)
                    2'd0: st.header_fields[31:24] = cur.header_fields[31:24] | b;
                    2'd1: st.header_fields[23:16] = cur.header_fields[23:16] | b;
                    2'd2: st.header_fields[15:8]  = cur.header_fields[15:8] | b;
                    2'd3: st.header_fields[7:0]   = cur.header_fields[7:0] | b;
                    default: st.header_fields = cur.header_fields;
                endcase
                if (cur.header_count != 2'd3)
                begin
                    st.header_count = cur.header_count + 2'd1;
                    kind            = KIND_HDR_BYTE;
                end
                else
                begin
                    st.header_count = 2'd0;
                    tkl             = st.header_fields[27:24];
                    if (tkl > MAX_TOKEN_BYTES)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_TOKEN_LONG;
                    end
                    else
                    begin
                        kind          = KIND_HDR_DONE;
                        st.item_index = '0;
                        st.remaining  = {13'd0, tkl};
                        st.phase      = (tkl != 4'd0) ? PH_TOKEN : PH_OPTHDR;
                    end
                end
            end
            PH_TOKEN, PH_VALUE:
            begin
                kind          = (cur.phase == PH_TOKEN) ? KIND_TOKEN : KIND_VALUE;
                idx           = cur.item_index;
                st.item_index = cur.item_index + 17'd1;
                if (cur.remaining != 17'd0)
                begin
                    st.remaining = cur.remaining - 17'd1;
                end
                if (st.remaining == 17'd0)
                begin
                    st.phase = PH_OPTHDR;
                end
            end
            PH_OPTHDR:
            begin
                if (b == 8'hFF)
                begin
                    st.phase      = PH_PAYLOAD;
                    st.item_index = '0;
                    kind          = KIND_HDR_BYTE;
                end
                else if (d == 4'd15 || l == 4'd15)
                begin
                    fail_now  = 1'b1;
                    fail_code = ERR_RESERVED;
                end
                else
                begin
                    st.pending   = b;
                    st.ext_count = {1'b0, dn} + {1'b0, ln};
                    st.ext_bytes = '0;
                    if (dn == 2'd0)
                    begin
                        delta = {13'd0, d};
                        sum   = {2'd0, cur.option_num} + {1'b0, delta};
                    end
                    if (sum[17:16] != 2'd0)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_OVERFLOW;
                    end
                    else
                    begin
                        if (dn == 2'd0)
                        begin
                            st.option_num = sum[15:0];
                        end
                        if (st.ext_count == 3'd0)
                        begin
                            start_now = 1'b1;
                            start_len = {13'd0, l};
                        end
                        else
                        begin
                            st.phase = PH_OPTEXT;
                            kind     = KIND_HDR_BYTE;
                        end
                    end
                end
            end
            PH_OPTEXT:
            begin
                st.ext_bytes = ext_new;
                if (cur.ext_count != 3'd0)
                begin
                    st.ext_count = cur.ext_count - 3'd1;
                end
                if (({1'b0, got} + 4'd1) == {2'd0, pdn})
                begin
                    delta        = ext_value(pdn, pd, ext_new);
                    st.ext_bytes = '0;
                    sum          = {2'd0, cur.option_num} + {1'b0, delta};
                    if (sum[17:16] != 2'd0)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ERR_OVERFLOW;
                    end
                    else
                    begin
                        st.option_num = sum[15:0];
                    end
                end
                if (!fail_now)
                begin
                    if (st.ext_count == 3'd0)
                    begin
                        start_now = 1'b1;
                        start_len = ext_value(pln, pl, st.ext_bytes);
                    end
                    else
                    begin
                        kind = KIND_HDR_BYTE;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                kind          = KIND_PAYLOAD;
                idx           = cur.item_index;
                st.item_index = cur.item_index + 17'd1;
            end
            default:
            begin
                st.phase = PH_DISCARD;
                kind     = KIND_ERROR;
            end
        endcase

        if (start_now)
        begin
            st.option_len = start_len;
            st.remaining  = start_len;
            st.item_index = '0;
            st.phase      = (start_len != 17'd0) ? PH_VALUE : PH_OPTHDR;
            kind          = KIND_OPT_DONE;
        end
        if (fail_now)
        begin
            st.err_latched = fail_code;
            st.phase       = PH_DISCARD;
            kind           = KIND_ERROR;
        end

        r0.kind          = kind;
        r0.version       = st.header_fields[31:30];
        r0.msg_type      = st.header_fields[29:28];
        r0.token_length  = st.header_fields[27:24];
        r0.code          = st.header_fields[23:16];
        r0.message_id    = st.header_fields[15:0];
        r0.option_number = st.option_num;
        r0.option_length = st.option_len;
        r0.byte_value    = b;
        r0.byte_index    = (kind == KIND_ERROR) ? 17'd0 : idx;
        r0.error_code    = (kind == KIND_ERROR) ? st.err_latched : ERR_NONE;
        r0.end_of_run    = (kind == KIND_ERROR) ? item.last_byte : !item.last_byte;

        unique case (st.phase)
            PH_HEADER: fin_err = ERR_SHORT_HDR;
            PH_TOKEN:  fin_err = ERR_TRUNC_TOKEN;
            PH_OPTEXT: fin_err = ERR_TRUNC_OPT;
            PH_VALUE:  fin_err = ERR_TRUNC_VALUE;
            default:   fin_err = ERR_NONE;
        endcase

        r1            = r0;
        r1.kind       = (fin_err != ERR_NONE) ? KIND_ERROR : KIND_OK;
        r1.byte_value = 8'd0;
        r1.byte_index = 17'd0;
        r1.error_code = fin_err;
        r1.end_of_run = 1'b1;

        res.first  = r0;
        res.second = r1;
        res.two    = item.last_byte && (kind != KIND_ERROR);

        nxt = item.last_byte ? STATE_CLEAR : st;
    end

endmodule

`default_nettype wire

// ===== rtl/coap_result_fifo.sv =====
// ============================================================================
// coap_result_fifo
// small result queue that takes one or two results per request and
// delivers one per cycle while the receiver pops
// ============================================================================
`default_nettype none

module coap_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  coap_pkg::step_t   entry,
    output logic              room,
    input  logic              pop,
    output logic              head_valid,
    output coap_pkg::result_t head
);
    import coap_pkg::*;

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_b;
    logic                  do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign room       = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign do_pop     = pop && head_valid;
    assign wr_ptr_b   = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + (entry.two ? FIFO_PTR_W'(2) : FIFO_PTR_W'(1));
            count_next  = count_next + (entry.two ? FIFO_CNT_W'(2) : FIFO_CNT_W'(1));
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(1);
            count_next  = count_next - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry.first;
            if (entry.two)
            begin
                mem_reg[wr_ptr_b] <= entry.second;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/coap_checker.sv =====
// ============================================================================
// coap_checker
// port-level checks of the coap message parser, bound to the top level
// ============================================================================
`default_nettype none

module coap_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_ready,
    input coap_pkg::byte_t   byte_item,
    input logic              result_valid,
    input logic              result_ready,
    input coap_pkg::result_t result_item
);
    import coap_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result changed while stalled");

    // empty queue always has room
    a_empty_room: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> byte_ready)
        else $error("byte channel blocked with empty queue");

    // a request taken while the output is empty makes the output valid in the next cycle
    a_request_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && !result_valid |=> result_valid)
        else $error("request produced no result");

    // the final result of a last byte follows right behind its byte result
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result_item.end_of_run &&
        result_item.kind != KIND_ERROR |=> result_valid)
        else $error("second result missing");

endmodule

bind coap_message_parser coap_checker u_checker (.*);

`default_nettype wire
